>>> design/latest_slot_lock_manager_unit_defines.svh
// Assertion macros for the latest-slot lock manager.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef LATEST_SLOT_LOCK_MANAGER_UNIT_DEFINES_SVH
`define LATEST_SLOT_LOCK_MANAGER_UNIT_DEFINES_SVH

`define LSLM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lslm assertion failed");

`define LSLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lslm assertion failed");

`endif

>>> design/lslm_pkg.sv
// Shared types and constants for the latest-slot lock manager.
// No dependencies.
`default_nettype none

package lslm_pkg;

    localparam int OPCODE_W = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 22;
    localparam int USED_W   = 7;
    localparam int SIU_W    = 7;
    localparam int EB_W     = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam int GRP_SIZE = 8;
    localparam int GRP_BW   = 3;

    localparam logic [SIU_W-1:0] SIU_RESET = 7'd64;
    localparam logic [EB_W-1:0]  EB_RESET  = 16'd10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WACQ = 2'd0,
        OP_WREL = 2'd1,
        OP_RACQ = 2'd2,
        OP_RREL = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        REG_SLOTS_IN_USE = 1'b0,
        REG_ENTRY_BYTES  = 1'b1
    } t_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> design/lslm_ctrl.sv
// Controller FSM: accepts one beat, then commits it into the result register.
// Depends on lslm_pkg.
`default_nettype none

module lslm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire lslm_pkg::t_dp_stat i_stat,
    output lslm_pkg::t_dp_cmd      o_cmd,
    output logic                   o_in_ready
);
    import lslm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.commit = !i_stat.out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/lslm_dp.sv
// Datapath: lock-word memory with nonzero flags, two-stage round-robin free-slot
// search, lock update, offset multiply and result register. Depends on lslm_pkg.
`default_nettype none

module lslm_dp #(
    parameter int SLOTS        = 64,
    parameter int READER_LIMIT = 63
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lslm_pkg::t_dp_cmd               i_cmd,
    output lslm_pkg::t_dp_stat                   o_stat,
    input  wire logic [lslm_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [lslm_pkg::SLOT_W-1:0]     i_slot,
    input  wire logic [lslm_pkg::SIU_W-1:0]      i_slots_in_use,
    input  wire logic [lslm_pkg::EB_W-1:0]       i_entry_bytes,
    input  wire logic                            i_out_ready,
    output logic [lslm_pkg::STATUS_W-1:0]        o_status,
    output logic [lslm_pkg::SLOT_W-1:0]          o_granted_slot,
    output logic [lslm_pkg::OFFSET_W-1:0]        o_byte_offset,
    output logic [lslm_pkg::USED_W-1:0]          o_slots_used
);
    import lslm_pkg::*;

    localparam int IW   = $clog2(SLOTS);
    localparam int LW   = $clog2(READER_LIMIT + 2);
    localparam int NW   = $clog2(SLOTS + 1);
    localparam int GRPS = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PADN = GRPS * GRP_SIZE;
    localparam logic [LW-1:0] WMARK = '1;
    localparam logic [LW-1:0] RLIM  = LW'(READER_LIMIT);

    // lock words; r_nz doubles as the valid flag (clear means zero)
    logic [LW-1:0]    r_mem [SLOTS];
    logic [SLOTS-1:0] r_nz;
    logic [LW-1:0]    r_rdata;
    logic [IW-1:0]    r_ridx;

    logic [IW-1:0]       r_next_write;
    logic [SLOT_W-1:0]   r_latest;
    logic [USED_W-1:0]   r_hw;
    t_op                 r_op;
    logic [SLOT_W-1:0]   r_slot;

    logic [GRPS-1:0]     r_hi_any;
    logic [GRPS-1:0]     r_all_any;
    logic [GRP_BW-1:0]   r_hi_first  [GRPS];
    logic [GRP_BW-1:0]   r_all_first [GRPS];

    logic                r_out_valid;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_gslot;
    logic [OFFSET_W-1:0] r_offset;
    logic [USED_W-1:0]   r_used;

    logic [NW-1:0]       scan_n;
    logic [IW-1:0]       scan_start;
    logic [PADN-1:0]     free_pad;
    logic [GRPS-1:0]     hi_any;
    logic [GRPS-1:0]     all_any;
    logic [GRP_BW-1:0]   hi_first  [GRPS];
    logic [GRP_BW-1:0]   all_first [GRPS];
    logic [IW-1:0]       rd_addr;

    logic                hi_found;
    logic                all_found;
    logic [IW-1:0]       hi_idx;
    logic [IW-1:0]       all_idx;
    logic [IW-1:0]       sel_idx;

    logic [LW-1:0]       word;
    logic                slot_ok;
    t_status             n_status;
    logic [SLOT_W-1:0]   n_gslot;
    logic [OFFSET_W-1:0] n_offset;
    logic [USED_W-1:0]   n_hw;
    logic [IW-1:0]       n_next_write;
    logic [SLOT_W-1:0]   n_latest;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [LW-1:0]       mem_wdata;
    logic                nz_we;
    logic                nz_val;

    assign o_stat.out_valid = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_slot   = r_gslot;
    assign o_byte_offset    = r_offset;
    assign o_slots_used     = r_used;

    always_comb begin
        if (i_slots_in_use == '0) begin
            scan_n = NW'(1);
        end else if (32'(i_slots_in_use) > SLOTS) begin
            scan_n = NW'(SLOTS);
        end else begin
            scan_n = NW'(i_slots_in_use);
        end
        scan_start = (32'(r_next_write) < 32'(scan_n)) ? r_next_write : '0;
    end

    assign free_pad = ~PADN'(r_nz) & PADN'({SLOTS{1'b1}});

    // stage one: per group of eight, first free slot at or after start, and overall
    always_comb begin
        for (int g = 0; g < GRPS; g++) begin
            hi_any[g]    = 1'b0;
            all_any[g]   = 1'b0;
            hi_first[g]  = '0;
            all_first[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (free_pad[g*GRP_SIZE+b] && (g*GRP_SIZE + b < 32'(scan_n))) begin
                    all_any[g]   = 1'b1;
                    all_first[g] = GRP_BW'(b);
                    if (g*GRP_SIZE + b >= 32'(scan_start)) begin
                        hi_any[g]   = 1'b1;
                        hi_first[g] = GRP_BW'(b);
                    end
                end
            end
        end
    end

    assign rd_addr = (t_op'(i_opcode) == OP_RACQ) ? IW'(r_latest) : IW'(i_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= t_op'(i_opcode);
            r_slot    <= i_slot;
            r_ridx    <= rd_addr;
            r_rdata   <= r_mem[rd_addr];
            r_hi_any  <= hi_any;
            r_all_any <= all_any;
            for (int g = 0; g < GRPS; g++) begin
                r_hi_first[g]  <= hi_first[g];
                r_all_first[g] <= all_first[g];
            end
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // stage two: lowest group wins, wrapped search as fallback
    always_comb begin
        hi_found  = 1'b0;
        all_found = 1'b0;
        hi_idx    = '0;
        all_idx   = '0;
        for (int g = GRPS - 1; g >= 0; g--) begin
            if (r_hi_any[g]) begin
                hi_found = 1'b1;
                hi_idx   = IW'(g*GRP_SIZE) + IW'(r_hi_first[g]);
            end
            if (r_all_any[g]) begin
                all_found = 1'b1;
                all_idx   = IW'(g*GRP_SIZE) + IW'(r_all_first[g]);
            end
        end
        sel_idx = hi_found ? hi_idx : all_idx;
    end

    assign word    = r_nz[r_ridx] ? r_rdata : '0;
    assign slot_ok = 32'(r_slot) < SLOTS;

    always_comb begin
        n_status     = ST_OK;
        n_gslot      = r_slot;
        n_hw         = r_hw;
        n_next_write = r_next_write;
        n_latest     = r_latest;
        mem_we       = 1'b0;
        mem_waddr    = r_ridx;
        mem_wdata    = word;
        nz_we        = 1'b0;
        nz_val       = 1'b0;
        case (r_op)
            OP_WACQ: begin
                if (hi_found || all_found) begin
                    n_gslot   = SLOT_W'(sel_idx);
                    mem_we    = 1'b1;
                    mem_waddr = sel_idx;
                    mem_wdata = WMARK;
                    nz_we     = 1'b1;
                    nz_val    = 1'b1;
                    if (32'(r_hw) <= 32'(sel_idx)) begin
                        n_hw = USED_W'(32'(sel_idx) + 1);
                    end
                    n_next_write = (32'(sel_idx) + 1 < 32'(scan_n)) ?
                                   IW'(32'(sel_idx) + 1) : '0;
                end else begin
                    n_status = ST_BUSY;
                    n_gslot  = '0;
                end
            end
            OP_WREL: begin
                if (!slot_ok || word != WMARK) begin
                    n_status = ST_BAD;
                end else begin
                    nz_we    = 1'b1;
                    nz_val   = 1'b0;
                    n_latest = r_slot;
                end
            end
            OP_RACQ: begin
                n_gslot = r_latest;
                if (word == WMARK || word >= RLIM) begin
                    n_status = ST_BUSY;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = word + LW'(1);
                    nz_we     = 1'b1;
                    nz_val    = 1'b1;
                end
            end
            OP_RREL: begin
                if (!slot_ok || word == '0 || word == WMARK) begin
                    n_status = ST_BAD;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = word - LW'(1);
                    nz_we     = 1'b1;
                    nz_val    = (word != LW'(1));
                end
            end
            default: n_status = ST_BAD;
        endcase
        n_offset = OFFSET_W'(n_gslot) * OFFSET_W'(i_entry_bytes);
        if (!i_cmd.commit) begin
            mem_we = 1'b0;
            nz_we  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz         <= '0;
            r_next_write <= '0;
            r_latest     <= '0;
            r_hw         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (nz_we) begin
                r_nz[mem_waddr] <= nz_val;
            end
            if (i_cmd.commit) begin
                r_next_write <= n_next_write;
                r_latest     <= n_latest;
                r_hw         <= n_hw;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_gslot  <= n_gslot;
            r_offset <= n_offset;
            r_used   <= n_hw;
        end
    end

endmodule

`default_nettype wire

>>> design/latest_slot_lock_manager_unit.sv
// Flow: one beat in flight at a time; no new beat is accepted until the last one commits.
// On accept the lock-word read and the first search stage are registered; in the
// EXEC state the round-robin search finishes and the result commits into the result
// register. A held result stalls the commit.
// Reset: synchronous, active low; clears all lock flags and pointers at once.
`default_nettype none
`include "latest_slot_lock_manager_unit_defines.svh"

module latest_slot_lock_manager_unit #(
    parameter int SLOTS        = 64,
    parameter int READER_LIMIT = 63
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [lslm_pkg::OPCODE_W-1:0]      i_opcode,
    input  wire logic [lslm_pkg::SLOT_W-1:0]        i_slot,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [lslm_pkg::STATUS_W-1:0]           o_status,
    output logic [lslm_pkg::SLOT_W-1:0]             o_granted_slot,
    output logic [lslm_pkg::OFFSET_W-1:0]           o_byte_offset,
    output logic [lslm_pkg::USED_W-1:0]             o_slots_used,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lslm_pkg::APB_AW-1:0]        paddr,
    input  wire logic [lslm_pkg::APB_DW-1:0]        pwdata,
    output logic [lslm_pkg::APB_DW-1:0]             prdata,
    output logic                                    pready
);
    import lslm_pkg::*;

    logic [SIU_W-1:0]    r_slots_in_use;
    logic [EB_W-1:0]     r_entry_bytes;
    logic                cfg_we;
    t_reg                cfg_reg;
    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic [OFFSET_W-1:0] chk_offset;

    assign pready  = 1'b1;
    assign cfg_reg = t_reg'(paddr[2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= SIU_RESET;
            r_entry_bytes  <= EB_RESET;
        end else if (cfg_we) begin
            case (cfg_reg)
                REG_SLOTS_IN_USE: r_slots_in_use <= pwdata[SIU_W-1:0];
                REG_ENTRY_BYTES:  r_entry_bytes  <= pwdata[EB_W-1:0];
                default:          r_entry_bytes  <= r_entry_bytes;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            REG_SLOTS_IN_USE: prdata = APB_DW'(r_slots_in_use);
            REG_ENTRY_BYTES:  prdata = APB_DW'(r_entry_bytes);
            default:          prdata = '0;
        endcase
    end

    lslm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .o_in_ready  (o_in_ready)
    );

    lslm_dp #(
        .SLOTS        (SLOTS),
        .READER_LIMIT (READER_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_opcode       (i_opcode),
        .i_slot         (i_slot),
        .i_slots_in_use (r_slots_in_use),
        .i_entry_bytes  (r_entry_bytes),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_byte_offset  (o_byte_offset),
        .o_slots_used   (o_slots_used)
    );

    assign o_out_valid = dp_stat.out_valid;
    assign chk_offset  = OFFSET_W'(o_granted_slot) * OFFSET_W'(r_entry_bytes);

    `LSLM_ASSERT_NEXT(a_one_beat_in_flight, o_in_ready && i_in_valid, !o_in_ready)
    `LSLM_ASSERT_NOW(a_result_after_exec, o_out_valid && !$past(o_out_valid), !$past(o_in_ready))
    `LSLM_ASSERT_NOW(a_offset_matches, o_out_valid, o_byte_offset == chk_offset)

endmodule

`default_nettype wire

>>> test/tb_latest_slot_lock_manager_unit.sv
// Self-checking testbench for latest_slot_lock_manager_unit: an in-bench lock table predicts
// each grant and compares it with the block. Register writes go over the APB port.
// Depends on lslm_pkg and the latest_slot_lock_manager_unit RTL.
`default_nettype none

module tb_latest_slot_lock_manager_unit;
    import lslm_pkg::*;

    localparam int NUM_SLOTS   = 64;
    localparam int READER_MAX  = 63;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 188;
    localparam logic [6:0] WRITER_MARK = 7'h7F;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
        logic [USED_W-1:0]   used;
    } t_grant;

    class lock_table_model;
        logic [6:0]        holders [NUM_SLOTS];
        int                wr_next;
        logic [SLOT_W-1:0] latest;
        logic [USED_W-1:0] high_water;
        logic [SIU_W-1:0]  scan_reg;
        logic [EB_W-1:0]   entry_bytes;
        t_grant            grants_due[$];
        int                mismatches;

        function new();
            foreach (holders[i]) holders[i] = '0;
            wr_next     = 0;
            latest      = '0;
            high_water  = '0;
            scan_reg    = SIU_RESET;
            entry_bytes = EB_RESET;
            mismatches  = 0;
        endfunction

        function void set_reg(t_reg r, logic [APB_DW-1:0] v);
            if (r == REG_SLOTS_IN_USE) scan_reg = v[SIU_W-1:0];
            else entry_bytes = v[EB_W-1:0];
        endfunction

        function int scan_len();
            if (scan_reg == 0) return 1;
            if (scan_reg > NUM_SLOTS) return NUM_SLOTS;
            return int'(scan_reg);
        endfunction

        // writer = 1 looks for a writer-held slot, else for one with readers
        function bit find_held(bit writer, output logic [SLOT_W-1:0] s);
            int start;
            int idx;
            start = $urandom_range(0, NUM_SLOTS - 1);
            for (int k = 0; k < NUM_SLOTS; k++) begin
                idx = (start + k) % NUM_SLOTS;
                if (writer ? holders[idx] == WRITER_MARK
                           : holders[idx] != 0 && holders[idx] != WRITER_MARK) begin
                    s = SLOT_W'(idx);
                    return 1'b1;
                end
            end
            s = SLOT_W'($urandom);
            return 1'b0;
        endfunction

        function void note_request(t_op op, logic [SLOT_W-1:0] s);
            t_grant g;
            int     n;
            int     idx;
            bit     found;
            g.status = ST_OK;
            g.slot   = s;
            case (op)
                OP_WACQ: begin
                    n = scan_len();
                    idx = (wr_next < n) ? wr_next : 0;
                    found = 1'b0;
                    for (int k = 0; k < n && !found; k++) begin
                        if (holders[idx] == 0) found = 1'b1;
                        else idx = (idx + 1 < n) ? idx + 1 : 0;
                    end
                    if (found) begin
                        holders[idx] = WRITER_MARK;
                        if (high_water <= idx) high_water = USED_W'(idx + 1);
                        wr_next = (idx + 1 < n) ? idx + 1 : 0;
                        g.slot = SLOT_W'(idx);
                    end else begin
                        g.status = ST_BUSY;
                        g.slot   = '0;
                    end
                end
                OP_RACQ: begin
                    g.slot = latest;
                    if (holders[latest] == WRITER_MARK || holders[latest] >= READER_MAX)
                        g.status = ST_BUSY;
                    else
                        holders[latest] = holders[latest] + 7'd1;
                end
                OP_WREL: begin
                    if (holders[s] != WRITER_MARK) begin
                        g.status = ST_BAD;
                    end else begin
                        holders[s] = '0;
                        latest = s;
                    end
                end
                default: begin
                    if (holders[s] == 0 || holders[s] == WRITER_MARK)
                        g.status = ST_BAD;
                    else
                        holders[s] = holders[s] - 7'd1;
                end
            endcase
            g.offset = OFFSET_W'(int'(g.slot) * int'(entry_bytes));
            g.used   = high_water;
            grants_due.push_back(g);
        endfunction

        function void check_grant(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] s,
                                  logic [OFFSET_W-1:0] off, logic [USED_W-1:0] used);
            t_grant want;
            if (grants_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected grant: status %0d slot %0d offset %0d used %0d",
                             st, s, off, used);
                return;
            end
            want = grants_due.pop_front();
            if (st !== want.status || s !== want.slot ||
                off !== want.offset || used !== want.used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("grant mismatch: exp status %0d slot %0d offset %0d used %0d, %s",
                             want.status, want.slot, want.offset, want.used,
                             $sformatf("got status %0d slot %0d offset %0d used %0d",
                                       st, s, off, used));
            end
        endfunction

        function int pending();
            return grants_due.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic [SLOT_W-1:0]   i_slot = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_granted_slot;
    logic [OFFSET_W-1:0] o_byte_offset;
    logic [USED_W-1:0]   o_slots_used;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lock_table_model lock_table = new();
    bit              steady = 1'b0;
    int              stall_cycles = 0;

    latest_slot_lock_manager_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_slot         (i_slot),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_byte_offset  (o_byte_offset),
        .o_slots_used   (o_slots_used),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            lock_table.check_grant(o_status, o_granted_slot, o_byte_offset, o_slots_used);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(t_op op, logic [SLOT_W-1:0] s);
        if (!steady && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_slot     <= s;
        do @(posedge i_clk); while (!o_in_ready);
        lock_table.note_request(op, s);
    endtask

    task automatic drain_grants();
        i_in_valid <= 1'b0;
        while (lock_table.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        lock_table.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [SIU_W-1:0] siu, logic [EB_W-1:0] eb);
        drain_grants();
        write_reg(REG_SLOTS_IN_USE, {25'($urandom), siu});
        write_reg(REG_ENTRY_BYTES, {16'($urandom), eb});
    endtask

    // Mostly well-formed acquire/release traffic; occasional reader floods push a
    // slot toward or up to the reader limit, then drain it again.
    task automatic run_random(int count);
        t_op               op;
        logic [SLOT_W-1:0] s;
        int                r;
        int                flood;
        int                drain;
        flood = 0;
        drain = 0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            s = SLOT_W'($urandom);
            if (flood == 0 && drain == 0 && $urandom_range(0, 249) == 0)
                flood = $urandom_range(60, 75);
            if (flood > 0) begin
                op = OP_RACQ;
                flood--;
                if (flood == 0) drain = 90;
            end else if (drain > 0 && lock_table.find_held(1'b0, s)) begin
                op = OP_RREL;
                drain--;
            end else if (r < 8) begin
                drain = 0;
                op = t_op'($urandom_range(0, 3));
                s = SLOT_W'($urandom);
            end else if (r < 30) begin
                op = OP_WACQ;
            end else if (r < 50) begin
                op = OP_WREL;
                void'(lock_table.find_held(1'b1, s));
            end else if (r < 75) begin
                op = OP_RACQ;
            end else begin
                op = OP_RREL;
                void'(lock_table.find_held(1'b0, s));
            end
            send_request(op, s);
        end
    endtask

    initial begin : stimulus
        logic [SIU_W-1:0] phase_siu [PHASES];
        logic [EB_W-1:0]  phase_eb [PHASES];
        logic [EB_W-1:0]  eb;
        phase_siu = '{7'd64, 7'd1, 7'd4, 7'd64, 7'd100, 7'd0, 7'd13, 7'd64, 7'd2, 7'd64};
        phase_eb  = '{16'd65535, 16'd0, 16'd1, 16'd3, 16'd4097, 16'd7, 16'd65535, 16'd5,
                      16'd10, 16'd2};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: reader on the initial latest, bad releases, writer cycle
        send_request(OP_RACQ, 6'd0);
        send_request(OP_RREL, 6'd0);
        send_request(OP_RREL, 6'd0);
        send_request(OP_WREL, 6'd63);
        send_request(OP_WACQ, 6'd21);
        send_request(OP_RACQ, 6'd0);
        send_request(OP_RREL, 6'd0);
        send_request(OP_WREL, 6'd0);
        send_request(OP_WACQ, 6'd0);
        send_request(OP_WREL, 6'd1);
        send_request(OP_RACQ, 6'd0);
        send_request(OP_RREL, 6'd42);

        // two-slot scan, stale start, no free slot, widest offset
        reconfigure(7'd2, 16'd65535);
        send_request(OP_WACQ, 6'd0);
        send_request(OP_WACQ, 6'd0);
        send_request(OP_WREL, 6'd63);
        send_request(OP_RREL, 6'd1);
        send_request(OP_WACQ, 6'd0);

        // zero scan size counts as one, zero entry size
        reconfigure(7'd0, 16'd0);
        send_request(OP_WACQ, 6'd0);
        send_request(OP_WREL, 6'd0);
        send_request(OP_RACQ, 6'd0);
        send_request(OP_WACQ, 6'd0);

        // oversized scan clamps to the full array
        reconfigure(7'd127, 16'd1);
        send_request(OP_WACQ, 6'd0);
        send_request(OP_RREL, 6'd0);

        for (int p = 0; p < PHASES; p++) begin
            eb = (p % 4 == 3) ? EB_W'($urandom) : phase_eb[p];
            reconfigure(phase_siu[p], eb);
            steady = (p == 3);
            run_random(PHASE_ITEMS);
        end
        steady = 1'b0;

        drain_grants();
        repeat (10) @(posedge i_clk);
        if (lock_table.mismatches == 0 && lock_table.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
